// ===== rtl/core/biq_pkg.sv =====
package biq_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int COEF_BITS     = 32;
	localparam int COEF_FRAC     = COEF_BITS - 4;
	localparam int Y_BITS        = SAMPLE_BITS + 4;
	localparam int STRENGTH_BITS = 18;
	localparam int STRENGTH_FRAC = 16;
	localparam int WEIGHT_BITS   = STRENGTH_BITS + 1;
	localparam int ACC_BITS      = 64;
	localparam int MUL_A_BITS    = (COEF_BITS > WEIGHT_BITS) ? COEF_BITS : WEIGHT_BITS;
	localparam int MUL_B_BITS    = Y_BITS;
	localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
	localparam int DATA_BITS     = 32;
	localparam int REG_COUNT     = 6;
	localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
	localparam int ADDR_BITS     = REG_IDX_BITS + 2;

	typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
	typedef logic signed [Y_BITS-1:0]        ysample_t;
	typedef logic signed [COEF_BITS-1:0]     coef_t;
	typedef logic signed [STRENGTH_BITS-1:0] strength_t;
	typedef logic signed [WEIGHT_BITS-1:0]   weight_t;
	typedef logic signed [MUL_A_BITS-1:0]    mula_t;
	typedef logic signed [MUL_B_BITS-1:0]    mulb_t;
	typedef logic signed [PROD_BITS-1:0]     prod_t;
	typedef logic signed [ACC_BITS-1:0]      acc_t;
	typedef logic [REG_IDX_BITS-1:0]         reg_idx_t;

	localparam coef_t     COEF_ONE     = coef_t'(64'd1 << COEF_FRAC);
	localparam strength_t STRENGTH_ONE = strength_t'(64'd1 << STRENGTH_FRAC);
	localparam weight_t   WEIGHT_ONE   = weight_t'(64'd1 << STRENGTH_FRAC);

	localparam reg_idx_t REG_B0  = reg_idx_t'(0);
	localparam reg_idx_t REG_B1  = reg_idx_t'(1);
	localparam reg_idx_t REG_B2  = reg_idx_t'(2);
	localparam reg_idx_t REG_A1  = reg_idx_t'(3);
	localparam reg_idx_t REG_A2  = reg_idx_t'(4);
	localparam reg_idx_t REG_MIX = reg_idx_t'(5);

	typedef enum logic [2:0] {
		SEL_B0X  = 3'd0,
		SEL_B1X1 = 3'd1,
		SEL_B2X2 = 3'd2,
		SEL_A1Y1 = 3'd3,
		SEL_A2Y2 = 3'd4,
		SEL_DRY  = 3'd5,
		SEL_WET  = 3'd6
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_CLR  = 2'd1,
		ACC_ADD  = 2'd2,
		ACC_SUB  = 2'd3
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     y_load;
		logic     commit;
	} biq_ctrl_t;

	typedef struct packed {
		coef_t     b0;
		coef_t     b1;
		coef_t     b2;
		coef_t     a1;
		coef_t     a2;
		strength_t mix;
	} biq_cfg_t;

endpackage

// ===== rtl/core/biq_if.sv =====
interface biq_in_if;
	import biq_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
	import biq_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/biquad_filter_wet_dry_mix_core.sv =====
// biquad filter (direct form I) with wet/dry mix
// din carries one signed Q1.23 sample per transaction; dout returns one mixed
// sample per input transaction, in order. both use valid/ready.
// configuration is written over the APB port (coef_b0..coef_a2 at 0x00..0x10,
// mix_strength at 0x14); write only while the block is idle. reads return
// the sign-extended register value.
// one shared multiplier forms seven products per sample (five filter taps,
// dry and wet weights) under a sequencer, with a register after each product
// and a separate rounding cycle for the filter output.
// din.ready is high only while the sequencer is idle.
// if dout stalls, the result waits in the output register; the next sample is
// still taken and processed, and the block holds in its last step until the
// output register frees up.
// reset clears the history samples, loads b0 = 1.0, other taps 0,
// mix_strength = 1.0, and empties the output register.
module biquad_filter_wet_dry_mix_core (
	input  logic                          clk,
	input  logic                          arst_n,
	biq_in_if.sink                        din,
	biq_out_if.source                     dout,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [biq_pkg::ADDR_BITS-1:0] paddr,
	input  logic [biq_pkg::DATA_BITS-1:0] pwdata,
	output logic [biq_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import biq_pkg::*;

	biq_cfg_t  cfg;
	biq_ctrl_t ctrl;
	sample_t   result;
	sample_t   out_data_q;
	logic      out_valid_q;
	logic      out_free;
	logic      out_load;
	logic      in_ready;

	assign out_free    = !out_valid_q || dout.ready;
	assign din.ready   = in_ready;
	assign dout.valid  = out_valid_q;
	assign dout.sample_out = out_data_q;

	biq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	biq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	biq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg),
		.sample_in (din.sample_in),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (dout.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= result;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> !din.ready)
		else $error("input taken while an item is in progress");

	a_commit_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> ctrl.commit && out_free)
		else $error("history update out of step with result");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> dout.valid && din.ready)
		else $error("result not presented after completion");

	a_first_tap: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> ctrl.mul_en && ctrl.mul_sel == SEL_B0X)
		else $error("sequencer did not start with the first tap");

endmodule

// ===== rtl/core/biq_regs.sv =====
module biq_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [biq_pkg::ADDR_BITS-1:0] paddr,
	input  logic [biq_pkg::DATA_BITS-1:0] pwdata,
	output logic [biq_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output biq_pkg::biq_cfg_t             cfg
);
	import biq_pkg::*;

	biq_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0  <= COEF_ONE;
			cfg_q.b1  <= '0;
			cfg_q.b2  <= '0;
			cfg_q.a1  <= '0;
			cfg_q.a2  <= '0;
			cfg_q.mix <= STRENGTH_ONE;
		end else if (wr) begin
			unique case (idx)
				REG_B0:  cfg_q.b0  <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_B1:  cfg_q.b1  <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_B2:  cfg_q.b2  <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_A1:  cfg_q.a1  <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_A2:  cfg_q.a2  <= coef_t'(pwdata[COEF_BITS-1:0]);
				REG_MIX: cfg_q.mix <= strength_t'(pwdata[STRENGTH_BITS-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_B0:  prdata = DATA_BITS'($signed(cfg_q.b0));
			REG_B1:  prdata = DATA_BITS'($signed(cfg_q.b1));
			REG_B2:  prdata = DATA_BITS'($signed(cfg_q.b2));
			REG_A1:  prdata = DATA_BITS'($signed(cfg_q.a1));
			REG_A2:  prdata = DATA_BITS'($signed(cfg_q.a2));
			REG_MIX: prdata = DATA_BITS'($signed(cfg_q.mix));
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/biq_dp.sv =====
module biq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  biq_pkg::biq_ctrl_t ctrl,
	input  biq_pkg::biq_cfg_t  cfg,
	input  biq_pkg::sample_t   sample_in,
	output biq_pkg::sample_t   result
);
	import biq_pkg::*;

	localparam acc_t Y_HI   = (acc_t'(1) <<< (Y_BITS - 1)) - acc_t'(1);
	localparam acc_t Y_LO   = ~Y_HI;
	localparam acc_t O_HI   = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
	localparam acc_t O_LO   = ~O_HI;
	localparam acc_t Y_HALF = acc_t'(1) <<< (COEF_FRAC - 1);
	localparam acc_t O_HALF = acc_t'(1) <<< (STRENGTH_FRAC - 1);

	sample_t  x_q, x1_q, x2_q;
	ysample_t y_q, y1_q, y2_q;
	acc_t     prod_q, acc_q;

	weight_t  dry_w;
	mula_t    mul_a;
	mulb_t    mul_b;
	prod_t    prod_w;
	acc_t     ysh, osh;
	ysample_t y_sat;

	assign dry_w  = WEIGHT_ONE - weight_t'(cfg.mix);
	assign prod_w = mul_a * mul_b;

	always_comb begin
		unique case (ctrl.mul_sel)
			SEL_B0X: begin
				mul_a = mula_t'(cfg.b0);
				mul_b = mulb_t'(x_q);
			end
			SEL_B1X1: begin
				mul_a = mula_t'(cfg.b1);
				mul_b = mulb_t'(x1_q);
			end
			SEL_B2X2: begin
				mul_a = mula_t'(cfg.b2);
				mul_b = mulb_t'(x2_q);
			end
			SEL_A1Y1: begin
				mul_a = mula_t'(cfg.a1);
				mul_b = mulb_t'(y1_q);
			end
			SEL_A2Y2: begin
				mul_a = mula_t'(cfg.a2);
				mul_b = mulb_t'(y2_q);
			end
			SEL_DRY: begin
				mul_a = mula_t'(dry_w);
				mul_b = mulb_t'(x_q);
			end
			SEL_WET: begin
				mul_a = mula_t'(cfg.mix);
				mul_b = mulb_t'(y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up, then clamp
	always_comb begin
		ysh = (acc_q + Y_HALF) >>> COEF_FRAC;
		osh = (acc_q + O_HALF) >>> STRENGTH_FRAC;
		if (ysh > Y_HI)
			y_sat = ysample_t'(Y_HI);
		else if (ysh < Y_LO)
			y_sat = ysample_t'(Y_LO);
		else
			y_sat = ysample_t'(ysh);
		if (osh > O_HI)
			result = sample_t'(O_HI);
		else if (osh < O_LO)
			result = sample_t'(O_LO);
		else
			result = sample_t'(osh);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load)
			x_q <= sample_in;
		if (ctrl.mul_en)
			prod_q <= acc_t'(prod_w);
		if (ctrl.y_load)
			y_q <= y_sat;
		unique case (ctrl.acc_op)
			ACC_CLR:  acc_q <= '0;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			ACC_SUB:  acc_q <= acc_q - prod_q;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctrl.commit) begin
			x2_q <= x1_q;
			x1_q <= x_q;
			y2_q <= y1_q;
			y1_q <= y_q;
		end
	end

endmodule

// ===== rtl/core/biq_seq.sv =====
module biq_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	output logic               in_ready,
	output logic               out_load,
	output biq_pkg::biq_ctrl_t ctrl
);
	import biq_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_M0   = 12'b0000_0000_0010,
		S_M1   = 12'b0000_0000_0100,
		S_M2   = 12'b0000_0000_1000,
		S_M3   = 12'b0000_0001_0000,
		S_M4   = 12'b0000_0010_0000,
		S_M5   = 12'b0000_0100_0000,
		S_Y    = 12'b0000_1000_0000,
		S_D    = 12'b0001_0000_0000,
		S_W    = 12'b0010_0000_0000,
		S_A    = 12'b0100_0000_0000,
		S_O    = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		ctrl.load    = 1'b0;
		ctrl.mul_en  = 1'b0;
		ctrl.mul_sel = SEL_B0X;
		ctrl.acc_op  = ACC_HOLD;
		ctrl.y_load  = 1'b0;
		ctrl.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load   = 1'b1;
					ctrl.acc_op = ACC_CLR;
					state_d     = S_M0;
				end
			end
			S_M0: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_B0X;
				state_d      = S_M1;
			end
			S_M1: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_B1X1;
				ctrl.acc_op  = ACC_ADD;
				state_d      = S_M2;
			end
			S_M2: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_B2X2;
				ctrl.acc_op  = ACC_ADD;
				state_d      = S_M3;
			end
			S_M3: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_A1Y1;
				ctrl.acc_op  = ACC_ADD;
				state_d      = S_M4;
			end
			S_M4: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_A2Y2;
				ctrl.acc_op  = ACC_SUB;
				state_d      = S_M5;
			end
			S_M5: begin
				ctrl.acc_op = ACC_SUB;
				state_d     = S_Y;
			end
			S_Y: begin
				ctrl.y_load = 1'b1;
				ctrl.acc_op = ACC_CLR;
				state_d     = S_D;
			end
			S_D: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_DRY;
				state_d      = S_W;
			end
			S_W: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = SEL_WET;
				ctrl.acc_op  = ACC_ADD;
				state_d      = S_A;
			end
			S_A: begin
				ctrl.acc_op = ACC_ADD;
				state_d     = S_O;
			end
			S_O: begin
				if (out_free) begin
					out_load    = 1'b1;
					ctrl.commit = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule
